// ----- design/spr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Systematic particle resampler package
// Request, response and configuration types, codes and fixed field widths.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned WEIGHT_W = 17;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic REG_COUNT = 1'b0;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_SUM  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NO_DRAW   = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [WEIGHT_W-1:0] weight;
		logic [FRAC_W-1:0]   random_fraction;
	} spr_req_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  selected_index;
		logic [STATUS_W-1:0] status;
		logic                last_draw;
	} spr_rsp_t;

	typedef struct packed {
		logic               wr;
		logic [COUNT_W-1:0] count;
	} spr_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_TEST
	} spr_state_t;

endpackage
`default_nettype wire

// ----- design/spr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spr_ram #(
	parameter int unsigned WIDTH = 27,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/spr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Resampler core
// Running-sum table in RAM, round checks, pointer walk and response register.
// ----------------------------------------------------------------------------
module spr_core #(
	parameter int unsigned MAX_PARTICLES        = 1024,
	parameter int unsigned WEIGHT_FRACTION_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire spr_pkg::spr_cfg_t cfg,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire spr_pkg::spr_req_t req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output spr_pkg::spr_rsp_t     rsp
);

	import spr_pkg::*;

	localparam int unsigned F  = WEIGHT_FRACTION_BITS;
	localparam int unsigned IW = $clog2(MAX_PARTICLES);
	localparam int unsigned LW = $clog2(MAX_PARTICLES + 1);
	localparam int unsigned CW = IW + F + 1;
	localparam int unsigned PW = CW + COUNT_W;
	localparam int unsigned XW = (WEIGHT_W > F + 1) ? WEIGHT_W : F + 1;
	localparam int unsigned TW = ((IW + 1 > COUNT_W) ? IW + 1 : COUNT_W) + 1;
	localparam int unsigned RW = FRAC_W + CW;
	localparam logic [TW-1:0] MAX_T = TW'(MAX_PARTICLES);
	localparam logic [LW-1:0] MAX_L = LW'(MAX_PARTICLES);
	localparam logic [XW-1:0] ONE_X = XW'(1) << F;
	localparam logic [FRAC_W-1:0] FMASK = FRAC_W'((64'd1 << F) - 64'd1);

	spr_state_t state_q, state_d;

	logic [LW-1:0]      lp_q;
	logic [CW-1:0]      total_q;
	logic [CW-1:0]      stride_q;
	logic [IW-1:0]      walk_q;
	logic [PW-1:0]      sp_q;
	logic [COUNT_W-1:0] draws_q;
	logic               active_q;
	logic [PW-1:0]      prod_q;
	logic               prod_vld_q;
	spr_rsp_t           rsp_q;
	logic               rsp_vld_q;

	logic               accept;
	logic               pop;
	logic [TW-1:0]      n_t;
	logic [TW-1:0]      walk_nx_t;
	logic [TW-1:0]      draws_nx_t;
	logic               n_bad;
	logic               adv;
	logic               last;
	logic [XW-1:0]      w_ext;
	logic [F:0]         w_sat;
	logic [CW-1:0]      total_add;
	logic [FRAC_W-1:0]  r_m;
	logic [RW-1:0]      rt;
	logic [PW-1:0]      sp_init;
	logic [STATUS_W-1:0] start_status;

	logic               do_load;
	logic               do_start;
	logic               test;
	logic               step;
	logic               finish;
	logic               push;
	spr_rsp_t           push_data;

	logic               mem_we;
	logic               mem_re;
	logic [IW-1:0]      mem_raddr;
	logic [CW-1:0]      mem_rdata;

	spr_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_PARTICLES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (lp_q[IW-1:0]),
		.wdata (total_add),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req_stall = (state_q != ST_IDLE) || (rsp_vld_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign pop       = rsp_vld_q && !rsp_stall;

	assign n_t        = TW'(cfg.count);
	assign walk_nx_t  = TW'(walk_q) + TW'(1);
	assign draws_nx_t = TW'(draws_q) + TW'(1);
	assign n_bad      = (cfg.count == '0) || (n_t > MAX_T);
	assign adv        = (walk_nx_t < n_t) && (sp_q > prod_q);
	assign last       = draws_nx_t >= n_t;

	assign w_ext     = XW'(req.weight);
	assign w_sat     = (w_ext > ONE_X) ? ONE_X[F:0] : w_ext[F:0];
	assign total_add = total_q + CW'(w_sat);
	assign r_m       = req.random_fraction & FMASK;
	assign rt        = RW'(r_m) * RW'(total_q);
	assign sp_init   = PW'(rt >> F);

	always_comb begin
		if (n_bad || (TW'(lp_q) != n_t)) begin
			start_status = STATUS_MISMATCH;
		end else if (total_q == '0) begin
			start_status = STATUS_ZERO_SUM;
		end else begin
			start_status = STATUS_OK;
		end
	end

	always_comb begin
		state_d   = state_q;
		do_load   = 1'b0;
		do_start  = 1'b0;
		test      = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = walk_q;
		push      = 1'b0;
		push_data = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.kind)
						KIND_LOAD: begin
							do_load = 1'b1;
							mem_we  = lp_q < MAX_L;
						end
						KIND_START: begin
							do_start         = 1'b1;
							push             = 1'b1;
							push_data.status = start_status;
						end
						KIND_DRAW: begin
							if (!active_q || n_bad) begin
								push             = 1'b1;
								push_data.status = STATUS_NO_DRAW;
							end else if (prod_vld_q) begin
								test = 1'b1;
							end else begin
								mem_re  = 1'b1;
								state_d = ST_FETCH;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: state_d = ST_TEST;
			ST_TEST:  test    = 1'b1;
			default:  state_d = ST_IDLE;
		endcase
		step   = test && adv;
		finish = test && !adv;
		if (step) begin
			mem_re    = 1'b1;
			mem_raddr = IW'(walk_nx_t);
			state_d   = ST_FETCH;
		end
		if (finish) begin
			push                     = 1'b1;
			push_data.selected_index = INDEX_W'(walk_q);
			push_data.status         = STATUS_OK;
			push_data.last_draw      = last;
			state_d                  = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			lp_q       <= '0;
			total_q    <= '0;
			walk_q     <= '0;
			sp_q       <= '0;
			draws_q    <= '0;
			active_q   <= 1'b0;
			prod_vld_q <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.wr) begin
				active_q   <= 1'b0;
				prod_vld_q <= 1'b0;
			end
			if (do_load) begin
				active_q <= 1'b0;
				if (lp_q < MAX_L) begin
					total_q <= total_add;
					lp_q    <= lp_q + LW'(1);
				end
			end
			if (do_start) begin
				lp_q       <= '0;
				total_q    <= '0;
				prod_vld_q <= 1'b0;
				active_q   <= start_status == STATUS_OK;
				if (start_status == STATUS_OK) begin
					walk_q  <= '0;
					draws_q <= '0;
					sp_q    <= sp_init;
				end
			end
			if (state_q == ST_FETCH) begin
				prod_vld_q <= 1'b1;
			end
			if (step) begin
				walk_q     <= IW'(walk_nx_t);
				prod_vld_q <= 1'b0;
			end
			if (finish) begin
				sp_q    <= sp_q + PW'(stride_q);
				draws_q <= draws_q + COUNT_W'(1);
				if (last) begin
					active_q <= 1'b0;
				end
			end
			if (push) begin
				rsp_vld_q <= 1'b1;
			end else if (pop) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_start) begin
			stride_q <= total_q;
		end
		if (state_q == ST_FETCH) begin
			prod_q <= PW'(mem_rdata) * PW'(cfg.count);
		end
		if (push) begin
			rsp_q <= push_data;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_walk_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (TW'(walk_q) < n_t))
		else $error("walk index beyond particle count");

	a_draws_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (TW'(draws_q) < n_t))
		else $error("draw count beyond particle count");

	a_fetch_then_test: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q == ST_TEST) && prod_vld_q)
		else $error("table fetch not followed by test");

	a_last_ends_round: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.last_draw) |=> !active_q)
		else $error("round still active after last draw");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_stall) |-> !push)
		else $error("held response overwritten");
`endif

endmodule
`default_nettype wire

// ----- design/systematic_particle_resampler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Systematic particle resampler
// Low-variance resampling of particle weights with an APB-style count register.
// ----------------------------------------------------------------------------
// A load request writes the next running sum into the table RAM; the response
// to a start request is valid from the next cycle. A draw request is answered
// without a table fetch while the pointer stays on the current table entry; for
// every entry the walk steps over, the block reads that entry from RAM,
// multiplies it by the particle count in the FETCH state and tests it in the
// TEST state. The first draw of a round also fetches entry zero first. Over a
// round of N draws the walk steps at most N-1 times. The table needs no
// clearing pass after reset. A new request is taken while a response waits in
// the output register, unless that response is held.
module systematic_particle_resampler #(
	parameter int unsigned MAX_PARTICLES        = 1024,
	parameter int unsigned WEIGHT_FRACTION_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [spr_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [spr_pkg::PDATA_W-1:0]     pwdata,
	output logic      [spr_pkg::PDATA_W-1:0]     prdata,
	output logic                                 pready,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire spr_pkg::spr_req_t               req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output spr_pkg::spr_rsp_t                    rsp
);

	import spr_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic               count_wr;
	spr_cfg_t           cfg;

	assign pready   = 1'b1;
	assign count_wr = psel && penable && pwrite && (paddr[2] == REG_COUNT);
	assign prdata   = (paddr[2] == REG_COUNT) ? PDATA_W'(count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (count_wr) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign cfg.wr    = count_wr;
	assign cfg.count = count_q;

	spr_core #(
		.MAX_PARTICLES        (MAX_PARTICLES),
		.WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ----- dv/systematic_particle_resampler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Systematic particle resampler testbench
// Loads weight rounds, starts them and draws indices through the request
// channel, with the particle count set over the APB port between rounds. Each
// accepted request updates a scoreboard that tracks the running sums, the
// scaled pointer and the table walk. Each response is compared field by field
// with the oldest answer it predicts. Directed rounds cover the edge cases.
// Random rounds follow under varying idle and stall patterns, a long
// receiver hold-off, and pauses that let the block drain.
// ----------------------------------------------------------------------------
module systematic_particle_resampler_tb;
	import spr_pkg::*;

	localparam int unsigned MAX_PARTICLES        = 1024;
	localparam int unsigned WEIGHT_FRACTION_BITS = 16;
	localparam int unsigned SUM_W                = 27;
	localparam int unsigned PTR_W                = 38;
	localparam logic [WEIGHT_W-1:0] FULL_WEIGHT  = 17'h10000;
	localparam logic [KIND_W-1:0]   KIND_UNUSED  = 2'd3;
	localparam logic [PADDR_W-1:0]  COUNT_ADDR   = {REG_COUNT, 2'b00};
	localparam int RANDOM_ITEMS   = 700;
	localparam int SETTLE_CYCLES  = 12;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 20000;

	class resample_scoreboard;
		logic [COUNT_W-1:0]  count;
		logic [SUM_W-1:0]    cum_sum [MAX_PARTICLES];
		logic [COUNT_W-1:0]  load_pos;
		logic [SUM_W-1:0]    weight_total;
		logic [INDEX_W-1:0]  walk_pos;
		logic [PTR_W-1:0]    pointer;
		logic [COUNT_W-1:0]  draws;
		bit                  round_open;
		spr_rsp_t            due_answers [$];
		int                  mismatches;

		function new();
			count = COUNT_RESET;
			foreach (cum_sum[i])
				cum_sum[i] = '0;
			load_pos = '0;
			weight_total = '0;
			walk_pos = '0;
			pointer = '0;
			draws = '0;
			round_open = 0;
			mismatches = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("%0t: %s", $time, msg);
			mismatches++;
		endtask

		function void note_count(input logic [COUNT_W-1:0] value);
			count = value;
			round_open = 0;
		endfunction

		function void note_request(input spr_req_t item);
			logic [WEIGHT_W-1:0] w;
			logic [STATUS_W-1:0] st;
			logic [SUM_W-1:0]    last_sum;
			logic [63:0]         product;
			case (item.kind)
				KIND_LOAD: begin
					w = (item.weight > FULL_WEIGHT) ? FULL_WEIGHT : item.weight;
					round_open = 0;
					if (load_pos < MAX_PARTICLES) begin
						weight_total = weight_total + SUM_W'(w);
						cum_sum[load_pos[INDEX_W-1:0]] = weight_total;
						load_pos = load_pos + 1'b1;
					end
				end
				KIND_START: begin
					st = STATUS_OK;
					if (count == 0 || count > MAX_PARTICLES || load_pos != count)
						st = STATUS_MISMATCH;
					else if (weight_total == 0)
						st = STATUS_ZERO_SUM;
					round_open = (st == STATUS_OK);
					if (round_open) begin
						walk_pos = '0;
						draws = '0;
						product = 64'(item.random_fraction) * 64'(weight_total);
						pointer = PTR_W'(product >> WEIGHT_FRACTION_BITS);
					end
					load_pos = '0;
					weight_total = '0;
					due_answers.push_back(spr_rsp_t'{INDEX_W'(0), st, 1'b0});
				end
				KIND_DRAW: begin
					if (!round_open || count == 0 || count > MAX_PARTICLES) begin
						due_answers.push_back(spr_rsp_t'{INDEX_W'(0), STATUS_NO_DRAW, 1'b0});
					end else begin
						last_sum = cum_sum[INDEX_W'(count - 1'b1)];
						while (int'(walk_pos) + 1 < int'(count) &&
						       pointer > PTR_W'(cum_sum[walk_pos]) * PTR_W'(count))
							walk_pos = walk_pos + 1'b1;
						pointer = pointer + PTR_W'(last_sum);
						draws = draws + 1'b1;
						if (draws >= count)
							round_open = 0;
						due_answers.push_back(spr_rsp_t'{walk_pos, STATUS_OK, draws >= count});
					end
				end
				default: ;
			endcase
		endfunction

		task check_response(input spr_rsp_t got);
			spr_rsp_t want;
			if (due_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected response index %0d status %0d last %0d",
					got.selected_index, got.status, got.last_draw));
			end else begin
				want = due_answers.pop_front();
				if (got.selected_index !== want.selected_index || got.status !== want.status ||
				    got.last_draw !== want.last_draw)
					report_mismatch($sformatf(
						"response index %0d/%0d status %0d/%0d last %0d/%0d (got/want)",
						got.selected_index, want.selected_index, got.status, want.status,
						got.last_draw, want.last_draw));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_stall;
	spr_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	spr_rsp_t rsp;

	resample_scoreboard sb = new();

	int sender_idle_pct = 25;
	int receiver_idle_pct = 51;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int hold_phase_done = -1;
	int counted_items = 0;
	int quiet_cycles = 0;

	systematic_particle_resampler #(
		.MAX_PARTICLES(MAX_PARTICLES),
		.WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (holds_served != hold_requests) begin
			rsp_stall <= 1'b1;
			holds_served = holds_served + 1;
			hold_left = HOLD_CYCLES;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_request(input spr_req_t item);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
		if (item.kind inside {KIND_LOAD, KIND_START, KIND_DRAW})
			counted_items++;
	endtask

	task automatic load_weight(input logic [WEIGHT_W-1:0] w);
		send_request(spr_req_t'{KIND_LOAD, w, FRAC_W'($urandom)});
	endtask

	task automatic start_round(input logic [FRAC_W-1:0] frac);
		send_request(spr_req_t'{KIND_START, WEIGHT_W'($urandom), frac});
	endtask

	task automatic draw_index();
		send_request(spr_req_t'{KIND_DRAW, WEIGHT_W'($urandom), FRAC_W'($urandom)});
	endtask

	task automatic wait_for_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.due_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write the count, then read it back
	task automatic program_count(input logic [COUNT_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COUNT_ADDR;
		pwdata <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.note_count(value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(value))
			sb.report_mismatch($sformatf("count read back %0d, written %0d", prdata, value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return '0;
		else if (roll < 15)
			return FULL_WEIGHT;
		else if (roll < 20)
			return WEIGHT_W'($urandom_range(32'h10001, 32'h1FFFF));
		else if (roll < 40)
			return WEIGHT_W'($urandom_range(0, 255));
		else
			return WEIGHT_W'($urandom_range(0, 32'h10000));
	endfunction

	function automatic logic [FRAC_W-1:0] pick_fraction();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		else
			return FRAC_W'($urandom);
	endfunction

	task automatic run_round(input int phase);
		int shape;
		int n;
		int loads;
		int draws;
		logic [COUNT_W-1:0] next_count;
		spr_req_t item;
		shape = $urandom_range(0, 9);
		if (shape < 9 && ($urandom_range(0, 2) == 0 || sb.count == 0 || sb.count > 64)) begin
			if ($urandom_range(0, 9) == 0)
				next_count = 1;
			else if ($urandom_range(0, 9) == 0)
				next_count = COUNT_W'($urandom_range(13, 64));
			else
				next_count = COUNT_W'($urandom_range(1, 12));
			wait_for_idle();
			program_count(next_count);
		end
		n = int'(sb.count);
		if (shape < 7) begin
			for (int i = 0; i < n; i++)
				load_weight(pick_weight());
			start_round(pick_fraction());
			if (hold_phase_done != phase && n >= 4) begin
				hold_requests++;
				hold_phase_done = phase;
			end
			draws = ($urandom_range(0, 6) == 0) ? $urandom_range(1, n) : n + $urandom_range(0, 1);
			for (int i = 0; i < draws; i++)
				draw_index();
		end else if (shape == 7) begin
			for (int i = 0; i < n; i++)
				load_weight('0);
			start_round(pick_fraction());
			draw_index();
		end else if (shape == 8) begin
			loads = $urandom_range(0, n + 1);
			for (int i = 0; i < loads; i++)
				load_weight(pick_weight());
			start_round(pick_fraction());
			draw_index();
			draw_index();
		end else begin
			repeat ($urandom_range(1, 6)) begin
				item.kind = KIND_W'($urandom_range(0, 3));
				item.weight = WEIGHT_W'($urandom);
				item.random_fraction = FRAC_W'($urandom);
				send_request(item);
			end
		end
	endtask

	initial begin
		int phase;
		int base;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		draw_index();
		send_request(spr_req_t'{KIND_UNUSED, WEIGHT_W'($urandom), FRAC_W'($urandom)});
		start_round(16'h1234);
		wait_for_idle();
		program_count(1);
		load_weight('0);
		start_round('1);
		draw_index();
		load_weight(17'h1FFFF);
		start_round('1);
		draw_index();
		draw_index();
		wait_for_idle();
		program_count(3);
		load_weight(FULL_WEIGHT);
		load_weight('0);
		load_weight(17'd1);
		start_round('0);
		draw_index();
		load_weight(17'd7);
		draw_index();
		start_round(16'h00FF);
		repeat (4) load_weight(17'd50);
		start_round(16'h4000);
		load_weight(17'd100);
		load_weight(17'd200);
		load_weight(17'd300);
		start_round(16'h8000);
		draw_index();
		wait_for_idle();
		program_count(3);
		draw_index();
		wait_for_idle();
		program_count(0);
		load_weight(17'd5);
		start_round(16'h0001);
		draw_index();
		wait_for_idle();
		program_count('1);
		start_round(16'hFFFE);
		wait_for_idle();
		program_count(COUNT_W'(MAX_PARTICLES));
		// fill the table; the last two loads fall past its end
		repeat (MAX_PARTICLES - 1) load_weight('0);
		load_weight(FULL_WEIGHT);
		load_weight(17'h1FFFF);
		load_weight(17'd9);
		start_round('1);
		repeat (3) draw_index();
		load_weight(17'd1);

		base = counted_items;
		phase = 0;
		while (counted_items - base < RANDOM_ITEMS) begin
			phase = (counted_items - base) * 3 / RANDOM_ITEMS;
			case (phase)
				0: begin
					sender_idle_pct = 25;
					receiver_idle_pct = 51;
				end
				1: begin
					sender_idle_pct = 51;
					receiver_idle_pct = 25;
				end
				default: begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
				end
			endcase
			run_round(phase);
		end

		wait_for_idle();
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
